@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed in fixed_partition_fit_allocator");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed in fixed_partition_fit_allocator");

`endif

@@ hw/rtl/fpfa_pkg.sv @@
// ----------------------------------------------------------------------------
// fpfa_pkg
// Sizes, command and policy codes and helpers for the partition allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fpfa_pkg;

  // Table geometry.
  localparam int PARTITIONS = 16;
  localparam int SIZE_WIDTH = 16;
  localparam int IDX_W      = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int CNT_W      = IDX_W + 1;
  localparam int SUM_W      = SIZE_WIDTH + IDX_W;

  // Fixed field widths.
  localparam int CMD_W    = 2;
  localparam int POLICY_W = 2;
  localparam int BCOUNT_W = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Fit policies.
  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;
  localparam logic [POLICY_W-1:0] POL_NEXT  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_POLICY      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd1;

  localparam logic [BCOUNT_W-1:0] BCOUNT_RESET = BCOUNT_W'(PARTITIONS);

  // Circular increment of a partition index within n live partitions.
  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] nx;
    nx = CNT_W'(idx) + CNT_W'(1);
    return (nx >= n) ? '0 : nx[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/fixed_partition_fit_allocator.sv @@
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator
// Fixed partition table with first, best, worst and next fit allocation.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Ports
// in       sink       in_valid/in_ready, command, block_index, block_size,
//                     request_size
// out      source     out_valid/out_ready, granted, granted_index, free_total
// cfg      sink       cfg_valid/cfg_ready, cfg_index, cfg_data
//
// A load, clear or unused command runs a summing pass for free_total over n
// table entries, n being the effective block count (1 to 16); an allocate
// first runs a fit search pass through the size subtractor. Both passes
// take one table entry a cycle.
// Reset (rst_n low, synchronous) frees every partition and clears the loaded
// flags; no clearing pass follows. A stalled result holds in the output
// register and the sequencer waits in its finish step until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_partition_fit_allocator import fpfa_pkg::*; (
  input  wire                    clk,
  input  wire                    rst_n,
  // Input items
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire  [CMD_W-1:0]       in_command,
  input  wire  [IDX_W-1:0]       in_block_index,
  input  wire  [SIZE_WIDTH-1:0]  in_block_size,
  input  wire  [SIZE_WIDTH-1:0]  in_request_size,
  // Result items
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic                   out_granted,
  output logic [IDX_W-1:0]       out_granted_index,
  output logic [SUM_W-1:0]       out_free_total,
  // Configuration writes
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire  [CFG_IDX_W-1:0]   cfg_index,
  input  wire  [CFG_DATA_W-1:0]  cfg_data
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_SUM    = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [POLICY_W-1:0]   policy_r, policy_nxt;
  logic [BCOUNT_W-1:0]   bcount_r, bcount_nxt;
  logic [PARTITIONS-1:0] loaded_r, loaded_nxt;
  logic [PARTITIONS-1:0] in_use_r, in_use_nxt;
  logic [IDX_W-1:0]      rover_r, rover_nxt;
  logic [IDX_W-1:0]      pos_r, pos_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  found_r, found_nxt;
  logic [IDX_W-1:0]      chosen_r, chosen_nxt;
  logic [SIZE_WIDTH-1:0] bestw_r, bestw_nxt;
  logic [SIZE_WIDTH-1:0] req_r, req_nxt;
  logic [SUM_W-1:0]      acc_r, acc_nxt;
  logic                  grant_r, grant_nxt;
  logic [IDX_W-1:0]      grant_idx_r, grant_idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_granted_r, out_granted_nxt;
  logic [IDX_W-1:0]      out_idx_r, out_idx_nxt;
  logic [SUM_W-1:0]      out_total_r, out_total_nxt;

  // Partition size table, written by loads only.
  logic [SIZE_WIDTH-1:0] sizes_r [PARTITIONS];
  logic [SIZE_WIDTH-1:0] cur_size_r;
  logic                  size_we;

  logic [CNT_W-1:0]      live_n;
  logic [IDX_W-1:0]      start_pos;
  logic [SIZE_WIDTH-1:0] cur_size;
  logic [SIZE_WIDTH:0]   waste_ext;
  logic [SIZE_WIDTH-1:0] waste;
  logic                  fit;
  logic                  better;
  logic                  stop_on_fit;
  logic                  last_entry;
  logic                  final_found;
  logic [IDX_W-1:0]      final_idx;
  logic                  in_acc;
  logic                  out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  // Effective block count: zero acts as one, the table size caps it.
  always_comb begin
    if (bcount_r == '0) begin
      live_n = CNT_W'(1);
    end else if (bcount_r > BCOUNT_W'(PARTITIONS)) begin
      live_n = CNT_W'(PARTITIONS);
    end else begin
      live_n = bcount_r[CNT_W-1:0];
    end
  end

  // Next fit starts at the rover, wrapped to zero when it lies outside.
  assign start_pos = (policy_r == POL_NEXT && CNT_W'(rover_r) < live_n) ? rover_r : '0;

  // Shared subtractor: waste of the entry under the scan pointer.
  assign cur_size    = cur_size_r;
  assign waste_ext   = {1'b0, cur_size} - {1'b0, req_r};
  assign waste       = waste_ext[SIZE_WIDTH-1:0];
  assign fit         = loaded_r[pos_r] && !in_use_r[pos_r] && !waste_ext[SIZE_WIDTH];
  assign stop_on_fit = (policy_r inside {POL_FIRST, POL_NEXT});
  assign better      = fit && (!found_r || (policy_r == POL_BEST && waste < bestw_r) ||
                               (policy_r == POL_WORST && waste > bestw_r));
  assign last_entry  = ((cnt_r + CNT_W'(1)) == live_n);
  assign final_found = found_r || better;
  assign final_idx   = better ? pos_r : chosen_r;

  // Sequencer and datapath next state.
  always_comb begin
    state_nxt     = state_r;
    policy_nxt    = policy_r;
    bcount_nxt    = bcount_r;
    loaded_nxt    = loaded_r;
    in_use_nxt    = in_use_r;
    rover_nxt     = rover_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    found_nxt     = found_r;
    chosen_nxt    = chosen_r;
    bestw_nxt     = bestw_r;
    req_nxt       = req_r;
    acc_nxt       = acc_r;
    grant_nxt     = grant_r;
    grant_idx_nxt = grant_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_granted_nxt = out_granted_r;
    out_idx_nxt   = out_idx_r;
    out_total_nxt = out_total_r;
    size_we       = 1'b0;

    // Configuration writes must arrive only while the block is idle; the block itself does not enforce it.
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_POLICY:      policy_nxt = cfg_data[POLICY_W-1:0];
        REG_BLOCK_COUNT: bcount_nxt = cfg_data[BCOUNT_W-1:0];
        default:         ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          grant_nxt     = 1'b0;
          grant_idx_nxt = '0;
          req_nxt       = in_request_size;
          pos_nxt       = '0;
          cnt_nxt       = '0;
          acc_nxt       = '0;
          found_nxt     = 1'b0;
          chosen_nxt    = '0;
          bestw_nxt     = '0;
          state_nxt     = ST_SUM;
          case (in_command)
            CMD_LOAD: begin
              size_we                    = 1'b1;
              loaded_nxt[in_block_index] = 1'b1;
              in_use_nxt[in_block_index] = 1'b0;
            end
            CMD_ALLOC: begin
              pos_nxt   = start_pos;
              state_nxt = ST_SEARCH;
              if (policy_r == POL_NEXT) begin
                rover_nxt = start_pos;
              end
            end
            CMD_CLEAR: begin
              in_use_nxt = '0;
              rover_nxt  = '0;
            end
            default: ;
          endcase
        end
      end

      // One candidate per cycle; first and next fit stop on the first hit.
      ST_SEARCH: begin
        if (better) begin
          found_nxt  = 1'b1;
          chosen_nxt = pos_r;
          bestw_nxt  = waste;
        end
        pos_nxt = wrap_inc(pos_r, live_n);
        cnt_nxt = cnt_r + CNT_W'(1);
        if (last_entry || (fit && stop_on_fit)) begin
          if (final_found) begin
            in_use_nxt[final_idx] = 1'b1;
            grant_nxt             = 1'b1;
            grant_idx_nxt         = final_idx;
            if (policy_r == POL_NEXT) begin
              rover_nxt = wrap_inc(final_idx, live_n);
            end
          end
          pos_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_SUM;
        end
      end

      // Add up the sizes of loaded, free partitions, one a cycle.
      ST_SUM: begin
        if (loaded_r[pos_r] && !in_use_r[pos_r]) begin
          acc_nxt = acc_r + SUM_W'(cur_size);
        end
        pos_nxt = pos_r + IDX_W'(1);
        cnt_nxt = cnt_r + CNT_W'(1);
        if (last_entry) begin
          state_nxt = ST_FINISH;
        end
      end

      // Hand the result to the output register once it is free.
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_granted_nxt = grant_r;
          out_idx_nxt     = grant_idx_r;
          out_total_nxt   = acc_r;
          state_nxt       = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      policy_r    <= POL_FIRST;
      bcount_r    <= BCOUNT_RESET;
      loaded_r    <= '0;
      in_use_r    <= '0;
      rover_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      policy_r    <= policy_nxt;
      bcount_r    <= bcount_nxt;
      loaded_r    <= loaded_nxt;
      in_use_r    <= in_use_nxt;
      rover_r     <= rover_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    pos_r         <= pos_nxt;
    cnt_r         <= cnt_nxt;
    found_r       <= found_nxt;
    chosen_r      <= chosen_nxt;
    bestw_r       <= bestw_nxt;
    req_r         <= req_nxt;
    acc_r         <= acc_nxt;
    grant_r       <= grant_nxt;
    grant_idx_r   <= grant_idx_nxt;
    out_granted_r <= out_granted_nxt;
    out_idx_r     <= out_idx_nxt;
    out_total_r   <= out_total_nxt;
  end

  // Size table write port, and a registered read of the entry the scan
  // pointer moves to. A load to that same entry is passed straight through.
  always_ff @(posedge clk) begin
    if (size_we) begin
      sizes_r[in_block_index] <= in_block_size;
    end
    if (size_we && (in_block_index == pos_nxt)) begin
      cur_size_r <= in_block_size;
    end else begin
      cur_size_r <= sizes_r[pos_nxt];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_granted       = out_granted_r;
  assign out_granted_index = out_idx_r;
  assign out_free_total    = out_total_r;

  // Checks on the sequencer.
  `include "assert_macros.svh"

  `ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state_r != ST_IDLE)
  `ASSERT_SAME(a_grant_marks_used, state_r == ST_FINISH && grant_r, in_use_r[grant_idx_r])
  `ASSERT_SAME(a_scan_in_range, state_r == ST_SEARCH, CNT_W'(pos_r) < live_n)
  `ASSERT_SAME(a_no_grant_zero_index, out_valid_r && !out_granted_r, out_idx_r == '0)

endmodule

`default_nettype wire

@@ test/fixed_partition_fit_allocator_checker.sv @@
// ----------------------------------------------------------------------------
// Partition allocator result checker
// Watches the input, result and configuration channels of the allocator,
// keeps its own copy of the partition table and fit settings, works out the
// outcome of every accepted item and compares each returned result with it.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator_checker import fpfa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [CMD_W-1:0]      in_command,
  input  logic [IDX_W-1:0]      in_block_index,
  input  logic [SIZE_WIDTH-1:0] in_block_size,
  input  logic [SIZE_WIDTH-1:0] in_request_size,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_granted,
  input  logic [IDX_W-1:0]      out_granted_index,
  input  logic [SUM_W-1:0]      out_free_total,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    items_accepted,
  output int                    results_taken,
  output int                    grants_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic             granted;
    logic [IDX_W-1:0] index;
    logic [SUM_W-1:0] total;
  } outcome_t;

  // Shadow of the partition table, the rover and the two registers.
  logic [SIZE_WIDTH-1:0] part_size   [PARTITIONS];
  logic                  part_loaded [PARTITIONS];
  logic                  part_busy   [PARTITIONS];
  logic [IDX_W-1:0]      rover;
  logic [POLICY_W-1:0]   fit_policy;
  logic [BCOUNT_W-1:0]   count_reg;
  outcome_t              pending_outcomes[$];

  // A partition can take the request if it is loaded, free and big enough.
  function automatic logic can_hold(int i, logic [SIZE_WIDTH-1:0] req);
    return part_loaded[i] && !part_busy[i] && (part_size[i] >= req);
  endfunction

  // Apply one item to the shadow table and return the result it produces.
  function automatic outcome_t compute_outcome(logic [CMD_W-1:0] cmd,
                                               logic [IDX_W-1:0] bidx,
                                               logic [SIZE_WIDTH-1:0] bsize,
                                               logic [SIZE_WIDTH-1:0] req);
    outcome_t o;
    int n;
    int i;
    int k;
    int start;
    int pick;
    int waste;
    int best_waste;
    logic [SUM_W-1:0] sum;

    // A count of zero acts as one, anything past the table as the full table.
    n = int'(count_reg);
    if (n == 0) n = 1;
    if (n > PARTITIONS) n = PARTITIONS;
    o.granted = 1'b0;
    o.index = '0;
    pick = -1;
    best_waste = 0;

    case (cmd)
      CMD_LOAD: begin
        part_size[bidx] = bsize;
        part_loaded[bidx] = 1'b1;
        part_busy[bidx] = 1'b0;
      end
      CMD_ALLOC: begin
        if (fit_policy == POL_NEXT) begin
          // Circular search from the rover, which first wraps if out of range.
          start = int'(rover);
          if (start >= n) start = 0;
          rover = IDX_W'(start);
          for (k = 0; k < n && pick < 0; k++) begin
            i = (start + k) % n;
            if (can_hold(i, req)) pick = i;
          end
          if (pick >= 0) rover = IDX_W'((pick + 1) % n);
        end else begin
          // First fit keeps the lowest candidate; best and worst compare waste.
          for (i = 0; i < n; i++) begin
            if (can_hold(i, req)) begin
              waste = int'(part_size[i]) - int'(req);
              if (pick < 0 ||
                  (fit_policy == POL_BEST && waste < best_waste) ||
                  (fit_policy == POL_WORST && waste > best_waste)) begin
                pick = i;
                best_waste = waste;
              end
            end
          end
        end
        if (pick >= 0) begin
          part_busy[pick] = 1'b1;
          o.granted = 1'b1;
          o.index = IDX_W'(pick);
        end
      end
      CMD_CLEAR: begin
        for (i = 0; i < PARTITIONS; i++) part_busy[i] = 1'b0;
        rover = '0;
      end
      default: begin
      end
    endcase

    // Free total over the live partitions, after the item took effect.
    sum = '0;
    for (i = 0; i < n; i++) begin
      if (part_loaded[i] && !part_busy[i]) sum = sum + SUM_W'(part_size[i]);
    end
    o.total = sum;
    return o;
  endfunction

  // All three channels are sampled at the rising edge.
  always @(posedge clk) begin
    outcome_t want;
    if (!rst_n) begin
      for (int i = 0; i < PARTITIONS; i++) begin
        part_loaded[i] = 1'b0;
        part_busy[i] = 1'b0;
      end
      rover = '0;
      fit_policy = POL_FIRST;
      count_reg = BCOUNT_RESET;
      pending_outcomes.delete();
      fail_count = 0;
      items_accepted = 0;
      results_taken = 0;
      grants_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_POLICY) fit_policy = cfg_data[POLICY_W-1:0];
        else if (cfg_index == REG_BLOCK_COUNT) count_reg = cfg_data[BCOUNT_W-1:0];
      end

      // Results are checked before this edge's input item is added.
      if (out_valid && out_ready) begin
        results_taken++;
        if (out_granted === 1'b1) grants_seen++;
        if (pending_outcomes.size() == 0) begin
          $error("unexpected result: granted=%0d granted_index=%0d free_total=%0d",
                 out_granted, out_granted_index, out_free_total);
          fail_count++;
        end else begin
          want = pending_outcomes.pop_front();
          if (out_granted !== want.granted) begin
            $error("granted: expected %0d, actual %0d", want.granted, out_granted);
            fail_count++;
          end
          if (out_granted_index !== want.index) begin
            $error("granted_index: expected %0d, actual %0d", want.index,
                   out_granted_index);
            fail_count++;
          end
          if (out_free_total !== want.total) begin
            $error("free_total: expected %0d, actual %0d", want.total, out_free_total);
            fail_count++;
          end
        end
      end

      if (in_valid && in_ready) begin
        items_accepted++;
        pending_outcomes.push_back(compute_outcome(in_command, in_block_index,
                                                   in_block_size, in_request_size));
      end
    end
  end

endmodule

@@ test/fixed_partition_fit_allocator_test.sv @@
// ----------------------------------------------------------------------------
// Partition allocator testbench
// Drives load, allocate, clear and unused commands into the allocator under
// every fit policy and a spread of block counts, with random gaps on the
// input side and random stalls on the result side, including one long stall
// that backs the block up. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fpfa_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_ITEMS = 1626;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 600000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [CMD_W-1:0]      in_command;
  logic [IDX_W-1:0]      in_block_index;
  logic [SIZE_WIDTH-1:0] in_block_size;
  logic [SIZE_WIDTH-1:0] in_request_size;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_granted;
  logic [IDX_W-1:0]      out_granted_index;
  logic [SUM_W-1:0]      out_free_total;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int items_accepted;
  int results_taken;
  int grants_seen;

  // Stimulus side bookkeeping, used only to aim requests at loaded sizes.
  int  known_size   [PARTITIONS] = '{default: 0};
  bit  known_loaded [PARTITIONS] = '{default: 0};
  int  live_count = PARTITIONS;
  int  phase_count = 0;
  int  cycle_count = 0;
  bit  no_idle = 1'b0;
  bit  wide_sizes = 1'b0;
  int  holds_asked = 0;
  int  holds_done = 0;

  fixed_partition_fit_allocator u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_block_index    (in_block_index),
    .in_block_size     (in_block_size),
    .in_request_size   (in_request_size),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_granted       (out_granted),
    .out_granted_index (out_granted_index),
    .out_free_total    (out_free_total),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  fixed_partition_fit_allocator_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_block_index    (in_block_index),
    .in_block_size     (in_block_size),
    .in_request_size   (in_request_size),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_granted       (out_granted),
    .out_granted_index (out_granted_index),
    .out_free_total    (out_free_total),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .items_accepted    (items_accepted),
    .results_taken     (results_taken),
    .grants_seen       (grants_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: a random stall before each item, plus the one long hold.
  initial begin
    int low_cycles;
    out_ready = 1'b0;
    while (!rst_n) @(negedge clk);
    forever begin
      low_cycles = no_idle ? 0 : $urandom_range(0, 8);
      if (holds_done != holds_asked) begin
        low_cycles = low_cycles + LONG_HOLD;
        holds_done = holds_asked;
      end
      if (low_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (low_cycles) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Offer one item after a random gap and return at the falling edge after
  // it was taken, with valid still high so the next item can follow at once.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] bidx,
                           input logic [SIZE_WIDTH-1:0] bsize,
                           input logic [SIZE_WIDTH-1:0] req);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_block_index <= bidx;
    in_block_size <= bsize;
    in_request_size <= req;
    if (cmd == CMD_LOAD) begin
      known_size[bidx] = int'(bsize);
      known_loaded[bidx] = 1'b1;
    end
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_load(input int bidx, input int bsize);
    send_item(CMD_LOAD, IDX_W'(bidx), SIZE_WIDTH'(bsize), SIZE_WIDTH'($urandom));
  endtask

  task automatic send_alloc(input int req);
    send_item(CMD_ALLOC, IDX_W'($urandom_range(0, 15)), SIZE_WIDTH'($urandom),
              SIZE_WIDTH'(req));
  endtask

  task automatic send_cmd(input logic [CMD_W-1:0] cmd);
    send_item(cmd, IDX_W'($urandom_range(0, 15)), SIZE_WIDTH'($urandom),
              SIZE_WIDTH'($urandom));
  endtask

  // Drop valid and wait until every accepted item has returned its result.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (results_taken != items_accepted) @(negedge clk);
  endtask

  // Write both registers back to back, holding valid across the pair.
  task automatic program_fit(input logic [CFG_DATA_W-1:0] pol_data,
                             input logic [CFG_DATA_W-1:0] count_data);
    cfg_valid <= 1'b1;
    cfg_index <= REG_POLICY;
    cfg_data <= pol_data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_index <= REG_BLOCK_COUNT;
    cfg_data <= count_data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    live_count = (count_data == 0) ? 1 : (count_data > PARTITIONS) ? PARTITIONS
                                                                   : int'(count_data);
    phase_count++;
  endtask

  // Random item, weighted toward loads and allocations aimed at real sizes.
  task automatic send_random_item();
    int roll;
    int pick;
    int req;
    int bsize;
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] bidx;

    roll = $urandom_range(0, 99);
    if (roll < 30) cmd = CMD_LOAD;
    else if (roll < 88) cmd = CMD_ALLOC;
    else if (roll < 96) cmd = CMD_CLEAR;
    else cmd = CMD_UNUSED;

    // Mostly live partitions, sometimes ones beyond the block count.
    if ($urandom_range(0, 99) < 85) bidx = IDX_W'($urandom_range(0, live_count - 1));
    else bidx = IDX_W'($urandom_range(0, 15));

    roll = $urandom_range(0, 99);
    if (roll < 5) bsize = 0;
    else if (roll < 10) bsize = 65535;
    else if (wide_sizes) bsize = $urandom_range(0, 65535);
    else bsize = $urandom_range(0, 255);

    // Requests near a loaded size hit the exact-fit and just-too-big cases.
    roll = $urandom_range(0, 99);
    pick = $urandom_range(0, live_count - 1);
    if (roll < 40 && known_loaded[pick]) begin
      req = known_size[pick] + $urandom_range(0, 2) - 1;
      if (req < 0) req = 0;
      if (req > 65535) req = 65535;
    end else if (roll < 65) begin
      req = $urandom_range(0, 255);
    end else if (roll < 85) begin
      req = $urandom_range(0, 65535);
    end else begin
      case ($urandom_range(0, 2))
        0: req = 0;
        1: req = 1;
        default: req = 65535;
      endcase
    end

    send_item(cmd, bidx, SIZE_WIDTH'(bsize), SIZE_WIDTH'(req));
  endtask

  // Main stimulus.
  initial begin
    int sent;
    int phase_len;
    int pol;
    int count_data;
    int pol_data;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_LOAD;
    in_block_index = '0;
    in_block_size = '0;
    in_request_size = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_POLICY;
    cfg_data = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: allocate from an empty table, load the size extremes,
    // a tie in size, then the unused command and a clear.
    send_alloc(0);
    send_load(15, 65535);
    send_load(0, 0);
    send_load(1, 100);
    send_load(2, 40);
    send_load(3, 300);
    send_load(4, 40);
    send_alloc(65535);
    send_alloc(1);
    send_cmd(CMD_UNUSED);
    send_cmd(CMD_CLEAR);

    // Best fit: two requests that tie on waste go to the lower index first.
    wait_idle();
    program_fit(POL_BEST, 16);
    send_alloc(30);
    send_alloc(30);

    // Worst fit picks the largest; then reload a partition that is in use.
    wait_idle();
    program_fit(POL_WORST, 16);
    send_alloc(0);
    send_load(2, 40);

    // Next fit over four partitions: the rover wraps and a search fails.
    // A load beyond the block count is kept for later.
    wait_idle();
    program_fit(POL_NEXT, 4);
    send_alloc(50);
    send_alloc(50);
    send_alloc(50);
    send_load(10, 500);

    // A block count of zero acts as one.
    wait_idle();
    program_fit(POL_NEXT, 0);
    send_alloc(0);

    // A count above the table acts as the full table, so partition 10 shows.
    wait_idle();
    program_fit(POL_FIRST, 31);
    send_alloc(400);

    // Move the rover to four, then shrink the count so it is out of range.
    wait_idle();
    program_fit(POL_NEXT, 17);
    send_cmd(CMD_CLEAR);
    send_alloc(200);
    wait_idle();
    program_fit(POL_NEXT, 2);
    send_alloc(0);

    // Random phases, each with its own policy, block count and pacing.
    sent = 0;
    for (int p = 0; sent < RANDOM_ITEMS; p++) begin
      pol = (p < 4) ? p : $urandom_range(0, 3);
      case (p)
        0: count_data = 1;
        1: count_data = 16;
        2: count_data = 0;
        3: count_data = 31;
        default: begin
          if ($urandom_range(0, 9) < 7) count_data = $urandom_range(1, 16);
          else if ($urandom_range(0, 2) == 0) count_data = 0;
          else count_data = $urandom_range(17, 31);
        end
      endcase
      // Upper data bits of a policy write are don't-care bits.
      pol_data = pol;
      if ($urandom_range(0, 3) == 0) pol_data = pol + ($urandom_range(0, 7) << 2);

      wait_idle();
      program_fit(CFG_DATA_W'(pol_data), CFG_DATA_W'(count_data));
      no_idle = ($urandom_range(0, 3) == 0);
      wide_sizes = ($urandom_range(0, 1) == 1);
      if (p == 5) begin
        // Long result stall while the sender keeps offering items.
        no_idle = 1'b1;
        holds_asked++;
      end
      phase_len = $urandom_range(30, 90);
      for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
        send_random_item();
        sent++;
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run covered %0d items with %0d grants over %0d register settings,",
             items_accepted, grants_seen, phase_count);
    $display("across all four fit policies and block counts from 0 to 31.");
    if (fail_count == 0 && results_taken == items_accepted) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/fpfa_pkg.sv
hw/rtl/fixed_partition_fit_allocator.sv
test/fixed_partition_fit_allocator_checker.sv
test/fixed_partition_fit_allocator_test.sv
